/* rtl/core/sbot_pkg.sv */
// ----------------------------------------------------------------------------
// sbot_pkg
// Shared constants for the segment versus box overlap test: axis indices,
// growth of the per-axis terms and the pipeline depth.
// ----------------------------------------------------------------------------
package sbot_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned AXIS_X   = 0;
  localparam int unsigned AXIS_Y   = 1;
  localparam int unsigned AXIS_Z   = 2;

  // extra bits over the coordinate width for extent/direction and offset
  localparam int unsigned E_GROW = 1;
  localparam int unsigned T_GROW = 2;

  // clock edges from the request edge to the edge that takes the result
  localparam int unsigned PIPE_DEPTH = 4;

endpackage

/* rtl/core/sbot_cross.sv */
// ----------------------------------------------------------------------------
// sbot_cross
// One cross-product axis test. Registers the four products, then the
// absolute difference and the projected extent; the final compare is
// combinational off the second register stage.
// ----------------------------------------------------------------------------
module sbot_cross #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                                                  clk,
  input  logic signed [COORD_BITS+sbot_pkg::T_GROW-1:0]         ti,
  input  logic signed [COORD_BITS+sbot_pkg::T_GROW-1:0]         tj,
  input  logic signed [COORD_BITS+sbot_pkg::E_GROW-1:0]         di,
  input  logic signed [COORD_BITS+sbot_pkg::E_GROW-1:0]         dj,
  input  logic signed [COORD_BITS+sbot_pkg::E_GROW-1:0]         ei,
  input  logic signed [COORD_BITS+sbot_pkg::E_GROW-1:0]         ej,
  output logic                                                  sep
);
  import sbot_pkg::*;

  localparam int unsigned EW = COORD_BITS + E_GROW;
  localparam int unsigned PW = 2 * COORD_BITS + E_GROW + T_GROW;
  localparam int unsigned QW = 2 * EW;
  localparam int unsigned LW = PW + 2;
  localparam int unsigned CW = PW + 3;

  logic signed [EW-1:0] abs_di;
  logic signed [EW-1:0] abs_dj;
  logic signed [PW-1:0] p_a;
  logic signed [PW-1:0] p_b;
  logic signed [QW-1:0] q_a;
  logic signed [QW-1:0] q_b;
  logic signed [LW-1:0] diff;
  logic signed [LW-1:0] lhs;
  logic signed [CW-1:0] rhs;

  assign abs_di = di[EW-1] ? -di : di;
  assign abs_dj = dj[EW-1] ? -dj : dj;
  assign diff   = LW'(p_a) - LW'(p_b);

  always_ff @(posedge clk) begin
    p_a <= PW'(ti) * PW'(dj);
    p_b <= PW'(tj) * PW'(di);
    q_a <= QW'(ei) * QW'(abs_dj);
    q_b <= QW'(ej) * QW'(abs_di);
    lhs <= diff[LW-1] ? -diff : diff;
    rhs <= CW'(q_a) + CW'(q_b);
  end

  assign sep = CW'(lhs) > rhs;

endmodule

/* rtl/core/segment_box_overlap_test_top.sv */
// ----------------------------------------------------------------------------
// segment_box_overlap_test_top
// Separating-axis overlap test of a line segment against an axis-aligned box.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the box corners and segment end points (signed Q16.8, COORD_BITS
//   wide) and raise start for one cycle per request. A request is taken at
//   every rising edge where start is high and busy is low; busy stays low,
//   so a new request may be issued in every cycle.
//   The answer appears on hit with done high for exactly one cycle, in request
//   order. hit is 1 when the segment touches or crosses the box, 0 when one of
//   the three face axes or three cross axes separates them.
//   Throughput is one request per cycle. There are four register stages:
//   per-axis terms, products and face tests, cross difference and extent,
//   then the final compare.
//   The receiver must take each result in the cycle done is high; there is
//   no back-pressure. Synchronous reset drops all requests in flight and
//   clears done.
// ----------------------------------------------------------------------------
module segment_box_overlap_test_top #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] box_min_x,
  input  logic signed [COORD_BITS-1:0] box_min_y,
  input  logic signed [COORD_BITS-1:0] box_min_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  input  logic signed [COORD_BITS-1:0] seg_start_x,
  input  logic signed [COORD_BITS-1:0] seg_start_y,
  input  logic signed [COORD_BITS-1:0] seg_start_z,
  input  logic signed [COORD_BITS-1:0] seg_end_x,
  input  logic signed [COORD_BITS-1:0] seg_end_y,
  input  logic signed [COORD_BITS-1:0] seg_end_z,
  output logic                         done,
  output logic                         hit
);
  import sbot_pkg::*;

  localparam int unsigned EW = COORD_BITS + E_GROW;
  localparam int unsigned TW = COORD_BITS + T_GROW;
  localparam int unsigned FW = TW + 1;

  logic signed [COORD_BITS-1:0] mn [NUM_AXES];
  logic signed [COORD_BITS-1:0] mx [NUM_AXES];
  logic signed [COORD_BITS-1:0] ss [NUM_AXES];
  logic signed [COORD_BITS-1:0] se [NUM_AXES];

  logic signed [EW-1:0] e [NUM_AXES];
  logic signed [TW-1:0] t [NUM_AXES];
  logic signed [EW-1:0] d [NUM_AXES];

  logic [NUM_AXES-1:0] face_bad;
  logic [NUM_AXES-1:0] cross_sep;
  logic                face_sep2;
  logic                face_sep3;
  logic                v1;
  logic                v2;
  logic                v3;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign mn[AXIS_X] = box_min_x;
  assign mn[AXIS_Y] = box_min_y;
  assign mn[AXIS_Z] = box_min_z;
  assign mx[AXIS_X] = box_max_x;
  assign mx[AXIS_Y] = box_max_y;
  assign mx[AXIS_Z] = box_max_z;
  assign ss[AXIS_X] = seg_start_x;
  assign ss[AXIS_Y] = seg_start_y;
  assign ss[AXIS_Z] = seg_start_z;
  assign se[AXIS_X] = seg_end_x;
  assign se[AXIS_Y] = seg_end_y;
  assign se[AXIS_Z] = seg_end_z;

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      e[a] <= EW'(mx[a]) - EW'(mn[a]);
      t[a] <= (TW'(mn[a]) + TW'(mx[a])) - (TW'(ss[a]) + TW'(se[a]));
      d[a] <= EW'(se[a]) - EW'(ss[a]);
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      face_bad[a] = FW'(t[a][TW-1] ? -t[a] : t[a]) >
                    (FW'(e[a]) + FW'(d[a][EW-1] ? -d[a] : d[a]));
    end
  end

  always_ff @(posedge clk) begin
    face_sep2 <= |face_bad;
    face_sep3 <= face_sep2;
    hit       <= !(face_sep3 || (|cross_sep));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  sbot_cross #(.COORD_BITS(COORD_BITS)) u_cross_x (
    .clk (clk),
    .ti  (t[AXIS_Y]),
    .tj  (t[AXIS_Z]),
    .di  (d[AXIS_Y]),
    .dj  (d[AXIS_Z]),
    .ei  (e[AXIS_Y]),
    .ej  (e[AXIS_Z]),
    .sep (cross_sep[AXIS_X])
  );

  sbot_cross #(.COORD_BITS(COORD_BITS)) u_cross_y (
    .clk (clk),
    .ti  (t[AXIS_Z]),
    .tj  (t[AXIS_X]),
    .di  (d[AXIS_Z]),
    .dj  (d[AXIS_X]),
    .ei  (e[AXIS_Z]),
    .ej  (e[AXIS_X]),
    .sep (cross_sep[AXIS_Y])
  );

  sbot_cross #(.COORD_BITS(COORD_BITS)) u_cross_z (
    .clk (clk),
    .ti  (t[AXIS_X]),
    .tj  (t[AXIS_Y]),
    .di  (d[AXIS_X]),
    .dj  (d[AXIS_Y]),
    .ei  (e[AXIS_X]),
    .ej  (e[AXIS_Y]),
    .sep (cross_sep[AXIS_Z])
  );

  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("request did not produce a result");

  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_DEPTH))
    else $error("result without a matching request");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe after reset");

endmodule

/* sim/segment_box_overlap_test_top_tb.sv */
// ----------------------------------------------------------------------------
// segment_box_overlap_test_top_tb
// Self-checking bench for the segment versus box overlap test. A short table
// of hand-picked requests (touching faces, full-range coordinates, inverted
// and degenerate boxes, point segments, cross-axis misses) is followed by
// random requests clustered around the box so that hits and misses both
// occur. Every hit strobe is compared in order against the value given in the
// table or a separating-axis predictor computed on exact integers.
// ----------------------------------------------------------------------------
module segment_box_overlap_test_top_tb;

  import sbot_pkg::*;

  localparam int unsigned CW        = 24;
  localparam int          CMIN      = -(1 << (CW - 1));
  localparam int          CMAX      = (1 << (CW - 1)) - 1;
  localparam int          FROM_PRED = -1;
  localparam int          N_RAND    = 1700;
  localparam int          N_STEADY  = 300;

  typedef struct packed {
    logic [NUM_AXES-1:0][CW-1:0] bmin;
    logic [NUM_AXES-1:0][CW-1:0] bmax;
    logic [NUM_AXES-1:0][CW-1:0] p0;
    logic [NUM_AXES-1:0][CW-1:0] p1;
  } seg_box_req_t;

  typedef struct {
    seg_box_req_t req;
    int           want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] box_min_x = '0;
  logic signed [CW-1:0] box_min_y = '0;
  logic signed [CW-1:0] box_min_z = '0;
  logic signed [CW-1:0] box_max_x = '0;
  logic signed [CW-1:0] box_max_y = '0;
  logic signed [CW-1:0] box_max_z = '0;
  logic signed [CW-1:0] seg_start_x = '0;
  logic signed [CW-1:0] seg_start_y = '0;
  logic signed [CW-1:0] seg_start_z = '0;
  logic signed [CW-1:0] seg_end_x = '0;
  logic signed [CW-1:0] seg_end_y = '0;
  logic signed [CW-1:0] seg_end_z = '0;
  logic                 done;
  logic                 hit;

  bit       hit_q[$];
  dir_row_t dir_tab[$];
  int       mismatch_cnt = 0;
  int       overlap_cnt = 0;
  int       apart_cnt = 0;
  bit       idle_on = 1'b1;

  segment_box_overlap_test_top #(
    .COORD_BITS(CW)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .box_min_x  (box_min_x),
    .box_min_y  (box_min_y),
    .box_min_z  (box_min_z),
    .box_max_x  (box_max_x),
    .box_max_y  (box_max_y),
    .box_max_z  (box_max_z),
    .seg_start_x(seg_start_x),
    .seg_start_y(seg_start_y),
    .seg_start_z(seg_start_z),
    .seg_end_x  (seg_end_x),
    .seg_end_y  (seg_end_y),
    .seg_end_z  (seg_end_z),
    .done       (done),
    .hit        (hit)
  );

  always #6 clk = ~clk;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit cross_apart(longint ti, longint tj, longint di, longint dj,
                                     longint ei, longint ej);
    longint lhs;
    longint rhs;
    lhs = mag(ti * dj - tj * di);
    rhs = ei * mag(dj) + ej * mag(di);
    return lhs > rhs;
  endfunction

  function automatic bit overlap_hit(seg_box_req_t r);
    longint ext[NUM_AXES];
    longint ofs[NUM_AXES];
    longint dir[NUM_AXES];
    longint lo, hi, p, q;
    bit     h;
    h = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo = $signed(r.bmin[a]);
      hi = $signed(r.bmax[a]);
      p  = $signed(r.p0[a]);
      q  = $signed(r.p1[a]);
      ext[a] = hi - lo;
      ofs[a] = (lo + hi) - (p + q);
      dir[a] = q - p;
      if (mag(ofs[a]) > ext[a] + mag(dir[a])) h = 1'b0;
    end
    if (cross_apart(ofs[AXIS_Y], ofs[AXIS_Z], dir[AXIS_Y], dir[AXIS_Z],
                    ext[AXIS_Y], ext[AXIS_Z])) h = 1'b0;
    if (cross_apart(ofs[AXIS_Z], ofs[AXIS_X], dir[AXIS_Z], dir[AXIS_X],
                    ext[AXIS_Z], ext[AXIS_X])) h = 1'b0;
    if (cross_apart(ofs[AXIS_X], ofs[AXIS_Y], dir[AXIS_X], dir[AXIS_Y],
                    ext[AXIS_X], ext[AXIS_Y])) h = 1'b0;
    return h;
  endfunction

  function automatic dir_row_t mk_row(int mnx, int mny, int mnz, int mxx, int mxy, int mxz,
                                      int sx, int sy, int sz, int ex, int ey, int ez,
                                      int want);
    dir_row_t row;
    row.req.bmin[AXIS_X] = mnx[CW-1:0];
    row.req.bmin[AXIS_Y] = mny[CW-1:0];
    row.req.bmin[AXIS_Z] = mnz[CW-1:0];
    row.req.bmax[AXIS_X] = mxx[CW-1:0];
    row.req.bmax[AXIS_Y] = mxy[CW-1:0];
    row.req.bmax[AXIS_Z] = mxz[CW-1:0];
    row.req.p0[AXIS_X]   = sx[CW-1:0];
    row.req.p0[AXIS_Y]   = sy[CW-1:0];
    row.req.p0[AXIS_Z]   = sz[CW-1:0];
    row.req.p1[AXIS_X]   = ex[CW-1:0];
    row.req.p1[AXIS_Y]   = ey[CW-1:0];
    row.req.p1[AXIS_Z]   = ez[CW-1:0];
    row.want             = want;
    return row;
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // mode 0: raw bits, 1: inverted box, 2: point segment, else box-local segment
  function automatic seg_box_req_t rand_req();
    seg_box_req_t r;
    int           mode, c, sc, h1, h2;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < NUM_AXES; a++) begin
      if (mode == 0) begin
        r.bmin[a] = CW'($urandom);
        r.bmax[a] = CW'($urandom);
        r.p0[a]   = CW'($urandom);
        r.p1[a]   = CW'($urandom);
      end else begin
        c  = spread(1 << 22);
        sc = 1 << $urandom_range(0, 14);
        h1 = $urandom_range(0, sc);
        h2 = $urandom_range(0, sc);
        if (mode == 1) begin
          r.bmin[a] = CW'(c + h2);
          r.bmax[a] = CW'(c - h1);
        end else begin
          r.bmin[a] = CW'(c - h1);
          r.bmax[a] = CW'(c + h2);
        end
        r.p0[a] = CW'(c + spread(2 * sc + 2));
        case ($urandom_range(0, 7))
          0: r.p0[a] = r.bmin[a];
          1: r.p0[a] = r.bmax[a];
          default: ;
        endcase
        if (mode == 2) begin
          r.p1[a] = r.p0[a];
        end else begin
          r.p1[a] = CW'(c + spread(2 * sc + 2));
          if ($urandom_range(0, 7) == 0) r.p1[a] = r.bmax[a];
        end
      end
    end
    return r;
  endfunction

  task automatic issue(input seg_box_req_t r, input int want);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    box_min_x   <= r.bmin[AXIS_X];
    box_min_y   <= r.bmin[AXIS_Y];
    box_min_z   <= r.bmin[AXIS_Z];
    box_max_x   <= r.bmax[AXIS_X];
    box_max_y   <= r.bmax[AXIS_Y];
    box_max_z   <= r.bmax[AXIS_Z];
    seg_start_x <= r.p0[AXIS_X];
    seg_start_y <= r.p0[AXIS_Y];
    seg_start_z <= r.p0[AXIS_Z];
    seg_end_x   <= r.p1[AXIS_X];
    seg_end_y   <= r.p1[AXIS_Y];
    seg_end_z   <= r.p1[AXIS_Z];
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    hit_q.push_back((want == FROM_PRED) ? overlap_hit(r) : want[0]);
  endtask

  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%b", $time, hit);
        mismatch_cnt++;
      end else begin
        if (hit !== hit_q[0]) begin
          $display("%0t: hit mismatch, expected %b, actual %b", $time, hit_q[0], hit);
          mismatch_cnt++;
        end
        if (hit === 1'b1) overlap_cnt++;
        else apart_cnt++;
        void'(hit_q.pop_front());
      end
    end
  end

  initial begin
    #(12 * 100000);
    $display("timeout with %0d results outstanding", hit_q.size());
    $display("segment_box_overlap_test_top test failed");
    $finish;
  end

  initial begin
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256, -512, 0, 0, 512, 0, 0, 1));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256, 0, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256, 1000, 0, 0, 1000, 0, 0, 0));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 1));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256, 257, 0, 0, 257, 0, 0, 0));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256, -512, 300, 0, 512, 300, 0, 0));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             256, -512, -512, 256, 512, 512, 1));
    dir_tab.push_back(mk_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                             CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0));
    dir_tab.push_back(mk_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                             CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1));
    dir_tab.push_back(mk_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                             CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1));
    dir_tab.push_back(mk_row(256, 256, 256, -256, -256, -256, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256, CMIN, 0, 0, CMAX, 0, 0, 1));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             300, -600, 0, 600, -300, 0, FROM_PRED));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             400, -100, 0, 100, -400, 0, FROM_PRED));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             512, 0, 0, 0, -512, 0, FROM_PRED));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             513, 0, 0, 0, -513, 0, FROM_PRED));
    dir_tab.push_back(mk_row(-256, -256, -256, 256, 256, 256,
                             0, 513, 200, 0, 0, 713, FROM_PRED));
    dir_tab.push_back(mk_row(-1000, -20, -300, 4000, 70, 900,
                             CMAX, CMIN, 0, CMIN, CMAX, 5, FROM_PRED));
    dir_tab.push_back(mk_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                             CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, FROM_PRED));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) issue(dir_tab[i].req, dir_tab[i].want);

    for (int n = 0; n < N_RAND; n++) begin
      idle_on = (n < N_RAND - N_STEADY);
      issue(rand_req(), FROM_PRED);
    end
    start <= 1'b0;

    while (hit_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("covered %0d table and %0d random requests", dir_tab.size(), N_RAND);
    $display("checked %0d overlaps and %0d separations", overlap_cnt, apart_cnt);
    if (mismatch_cnt == 0) begin
      $display("segment_box_overlap_test_top test passed");
    end else begin
      $display("segment_box_overlap_test_top test failed");
    end
    $finish;
  end

endmodule
